// ===== rtl/lrupr_pkg.sv =====
`default_nettype none

package lrupr_pkg;

    localparam int MAX_FRAMES = 8;
    localparam int PAGE_W     = 10;
    localparam int FRAME_W    = 3;
    localparam int FILL_W     = 4;
    localparam int COUNT_W    = 16;

    localparam logic [FILL_W-1:0]  FILL_FULL = FILL_W'(MAX_FRAMES);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              last_request;
    } in_t;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame_index;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
        logic [COUNT_W-1:0] fault_count;
        logic               last;
    } out_t;

    // search token walking the cell chain
    typedef struct packed {
        logic               active;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] oldest_rank;
        logic               hit;
        logic [FRAME_W-1:0] hit_idx;
        logic [FRAME_W-1:0] hit_rank;
        logic [FRAME_W-1:0] victim_idx;
        logic [PAGE_W-1:0]  victim_page;
    } tok_t;

    // update broadcast to every cell
    typedef struct packed {
        logic               clear;
        logic               en;
        logic [FRAME_W-1:0] target;
        logic [FILL_W-1:0]  old_rank;
        logic               write_page;
        logic [PAGE_W-1:0]  page;
    } upd_t;

endpackage

`default_nettype wire

// ===== rtl/lrupr_cell.sv =====
`default_nettype none

module lrupr_cell
    import lrupr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [FRAME_W-1:0] idx,
    input  wire tok_t               tok_in,
    output tok_t                    tok_out,
    input  wire upd_t               upd
);

    logic [PAGE_W-1:0]  page_reg;
    logic               valid_reg;
    logic [FRAME_W-1:0] rank_reg;
    tok_t               tok_reg;
    tok_t               tok_next;

    // compare this frame against the passing token
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.active && valid_reg)
        begin
            if (!tok_in.hit && page_reg == tok_in.page)
            begin
                tok_next.hit      = 1'b1;
                tok_next.hit_idx  = idx;
                tok_next.hit_rank = rank_reg;
            end
            if (rank_reg == tok_in.oldest_rank)
            begin
                tok_next.victim_idx  = idx;
                tok_next.victim_page = page_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg   <= '0;
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (upd.clear)
            begin
                valid_reg <= 1'b0;
                rank_reg  <= '0;
            end
            else if (upd.en)
            begin
                if (upd.target == idx)
                begin
                    valid_reg <= 1'b1;
                    rank_reg  <= '0;
                end
                else if (valid_reg && ({1'b0, rank_reg} < upd.old_rank))
                begin
                    rank_reg <= rank_reg + 1'b1;
                end
            end
        end
    end

    // page store: no reset, undefined until first fill
    always_ff @(posedge clk)
    begin
        if (!upd.clear && upd.en && upd.write_page && upd.target == idx)
            page_reg <= upd.page;
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// ===== rtl/lru_page_replacement.sv =====
// LRU page replacement over a table of up to eight page frames.
//
// Input channel (in_valid / in_ready / in_data): one word per page reference,
// carrying the page number and a last_request marker. Output channel
// (out_valid / out_ready / out_data): one word per reference with hit/miss,
// the frame now holding the page, any evicted page, the saturating fault
// count and the echoed marker.
// Configuration: cfg_we with cfg_data writes frames_in_use (0 acts as 1,
// above eight acts as eight) and empties the frame table; the fault count
// survives. Write only while the block is idle.
// Each frame lives in one cell of an eight-cell chain. An accepted reference
// launches a search word that walks one cell per cycle, picking up the hit
// frame and the oldest frame; the result is then decided and one update is
// broadcast to all cells, and the result word is registered for output.
// A new reference is taken only once the previous result has committed, so
// one reference is searched at a time.
// in_ready is low until the result commits. If the receiver stalls, the output
// register holds its word and the next reference may still be accepted and
// searched; it waits for the output register before committing.
// Reset (rst_n, asynchronous, active low): table empty, frames_in_use = 8,
// fault count zero, both channels idle.
`default_nettype none

module lru_page_replacement
    import lrupr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire in_t               in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output out_t                   out_data,
    input  wire logic              cfg_we,
    input  wire logic [FILL_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_DECIDE = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [FILL_W-1:0]  fiu_reg;        // raw frames_in_use
    logic [FILL_W-1:0]  filled_reg, filled_next;
    logic [COUNT_W-1:0] fault_reg, fault_next;
    logic               last_reg;
    tok_t               fin_reg;
    logic               out_valid_reg, out_valid_next;
    out_t               out_reg, out_next;

    logic [FILL_W-1:0]  cap;
    logic               in_acc;
    logic               commit;
    tok_t               tok_link [0:MAX_FRAMES];
    upd_t               upd;

    // effective capacity after clamping
    always_comb
    begin
        if (fiu_reg == '0)
            cap = FILL_W'(1);
        else if (fiu_reg > FILL_FULL)
            cap = FILL_FULL;
        else
            cap = fiu_reg;
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign in_acc   = in_valid && in_ready;
    // result may commit once the output register is free or being drained
    assign commit   = (state_reg == ST_DECIDE) && (!out_valid_reg || out_ready);

    // head of the chain: search word launched on acceptance
    always_comb
    begin
        tok_link[0]             = '0;
        tok_link[0].active      = in_acc;
        tok_link[0].page        = in_data.page;
        tok_link[0].oldest_rank = FRAME_W'(filled_reg - 1'b1);
    end

    for (genvar g = 0; g < MAX_FRAMES; g++)
    begin : g_cell
        lrupr_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .idx     (FRAME_W'(g)),
            .tok_in  (tok_link[g]),
            .tok_out (tok_link[g+1]),
            .upd     (upd)
        );
    end

    // decision and table update
    always_comb
    begin
        state_next     = state_reg;
        filled_next    = filled_reg;
        fault_next     = fault_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        upd            = '0;
        upd.page       = fin_reg.page;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                    state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (tok_link[MAX_FRAMES].active)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (commit)
                begin
                    upd.en                 = 1'b1;
                    out_next.hit           = fin_reg.hit;
                    out_next.evicted_valid = 1'b0;
                    out_next.evicted_page  = '0;
                    out_next.last          = last_reg;
                    if (fin_reg.hit)
                    begin
                        upd.target   = fin_reg.hit_idx;
                        upd.old_rank = {1'b0, fin_reg.hit_rank};
                    end
                    else
                    begin
                        upd.write_page = 1'b1;
                        if (fault_reg != COUNT_MAX)
                            fault_next = fault_reg + 1'b1;
                        if (filled_reg < cap)
                        begin
                            // fill next empty frame; every resident frame ages
                            upd.target   = FRAME_W'(filled_reg);
                            upd.old_rank = FILL_FULL;
                            filled_next  = filled_reg + 1'b1;
                        end
                        else
                        begin
                            upd.target             = fin_reg.victim_idx;
                            upd.old_rank           = {1'b0, fin_reg.oldest_rank};
                            out_next.evicted_valid = 1'b1;
                            out_next.evicted_page  = fin_reg.victim_page;
                        end
                    end
                    out_next.frame_index = upd.target;
                    out_next.fault_count = fault_next;
                    out_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a capacity write empties the table
        if (cfg_we)
        begin
            upd.clear   = 1'b1;
            filled_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fiu_reg       <= FILL_FULL;
            filled_reg    <= '0;
            fault_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            filled_reg    <= filled_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                fiu_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (in_acc)
            last_reg <= in_data.last_request;
        if (state_reg == ST_SEARCH && tok_link[MAX_FRAMES].active)
            fin_reg <= tok_link[MAX_FRAMES];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // the search word leaves the chain only while a search runs
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_link[MAX_FRAMES].active |-> state_reg == ST_SEARCH)
        else $error("search word left chain outside search");

    // fill count never exceeds the clamped capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= cap)
        else $error("fill count above capacity");

    // fault count never goes backwards
    assert property (@(posedge clk) disable iff (!rst_n)
        ##1 fault_reg >= $past(fault_reg))
        else $error("fault count decreased");

    // a hit neither evicts nor counts a fault
    assert property (@(posedge clk) disable iff (!rst_n)
        commit && fin_reg.hit |=> !out_reg.evicted_valid && fault_reg == $past(fault_reg))
        else $error("hit evicted or counted a fault");

    // a committed result always lands in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("committed result lost");

endmodule

`default_nettype wire

// ===== sim/page_table_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels and the capacity port of lru_page_replacement.
// It keeps its own copy of the frame table, works out each result word
// and compares it with what the block returns.
module page_table_checker
    import lrupr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire in_t               in_data,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire out_t              out_data,
    input  wire logic              cfg_we,
    input  wire logic [FILL_W-1:0] cfg_data,
    output int                     mismatches,
    output int                     pending
);

    localparam int PRINT_MAX = 50;

    logic [PAGE_W-1:0]  frame_page  [MAX_FRAMES];
    logic               frame_valid [MAX_FRAMES];
    logic [FRAME_W-1:0] frame_age   [MAX_FRAMES];
    int                 frames_filled;
    logic [FILL_W-1:0]  frames_reg;
    logic [COUNT_W-1:0] faults;
    out_t               expected_words [$];

    task automatic report(string what);
        if (mismatches < PRINT_MAX)
            $display("%0t ns: %s", $time, what);
        mismatches++;
    endtask

    function automatic void empty_table();
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            frame_valid[i] = 1'b0;
            frame_age[i]   = '0;
        end
        frames_filled = 0;
    endfunction

    // frame f becomes newest; every valid frame younger than it ages by one
    function automatic void make_newest(int f, int old_age);
        for (int i = 0; i < MAX_FRAMES; i++)
            if (i != f && frame_valid[i] && frame_age[i] < old_age)
                frame_age[i] = frame_age[i] + 1'b1;
        frame_age[f] = '0;
    endfunction

    function automatic out_t replace_page(in_t w);
        out_t r;
        int   cap;
        int   f;
        int   oldest;
        bit   found;
        r      = '0;
        r.last = w.last_request;
        f      = 0;
        oldest = 0;
        found  = 1'b0;
        cap = (frames_reg == 0) ? 1 :
              (frames_reg > MAX_FRAMES) ? MAX_FRAMES : int'(frames_reg);
        for (int i = 0; i < cap; i++)
            if (!r.hit && frame_valid[i] && frame_page[i] == w.page)
            begin
                r.hit = 1'b1;
                f     = i;
            end
        if (r.hit)
            make_newest(f, frame_age[f]);
        else
        begin
            if (frames_filled < cap)
            begin
                // fill in index order; a new frame starts newest and every other valid frame ages
                f              = frames_filled;
                frame_valid[f] = 1'b1;
                frame_page[f]  = w.page;
                frames_filled++;
                make_newest(f, MAX_FRAMES);
            end
            else
            begin
                for (int i = 0; i < cap; i++)
                    if (frame_valid[i] && (!found || frame_age[i] > oldest))
                    begin
                        oldest = frame_age[i];
                        f      = i;
                        found  = 1'b1;
                    end
                r.evicted_valid = 1'b1;
                r.evicted_page  = frame_page[f];
                frame_page[f]   = w.page;
                make_newest(f, frame_age[f]);
            end
            if (faults != COUNT_MAX)
                faults++;
        end
        r.frame_index = FRAME_W'(f);
        r.fault_count = faults;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            frames_reg = FILL_FULL;
            empty_table();
            faults     = '0;
            expected_words.delete();
            mismatches = 0;
            pending   <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                frames_reg = cfg_data;
                empty_table();
            end
            if (in_valid && in_ready)
                expected_words.push_back(replace_page(in_data));
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                    report($sformatf("result word with nothing expected, fault_count %0d",
                                     out_data.fault_count));
                else
                begin
                    want = expected_words.pop_front();
                    if (out_data.hit != want.hit)
                        report($sformatf("hit %0d, expected %0d",
                                         out_data.hit, want.hit));
                    if (out_data.frame_index != want.frame_index)
                        report($sformatf("frame_index %0d, expected %0d",
                                         out_data.frame_index, want.frame_index));
                    if (out_data.evicted_valid != want.evicted_valid)
                        report($sformatf("evicted_valid %0d, expected %0d",
                                         out_data.evicted_valid, want.evicted_valid));
                    if (out_data.evicted_page != want.evicted_page)
                        report($sformatf("evicted_page %0d, expected %0d",
                                         out_data.evicted_page, want.evicted_page));
                    if (out_data.fault_count != want.fault_count)
                        report($sformatf("fault_count %0d, expected %0d",
                                         out_data.fault_count, want.fault_count));
                    if (out_data.last != want.last)
                        report($sformatf("last %0d, expected %0d",
                                         out_data.last, want.last));
                end
            end
            pending <= expected_words.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for lru_page_replacement. Prediction and comparison
// live in page_table_checker, which sits beside the block and hands back a
// mismatch count and the number of words still owed.
module tb;
    import lrupr_pkg::*;

    localparam int LIMIT         = 200_000;    // cycles, well above the slowest run
    localparam int HOLD_CYCLES   = 400;        // long receiver hold-off
    localparam int PHASE_WORDS   = 200;
    localparam int RANDOM_PHASES = 8;
    localparam int SAT_WORDS     = 10;         // single-frame thrash run
    localparam int WS_REFRESH    = 40;         // words between working-set moves

    // idling modes, cycled through phase by phase
    localparam int MODE_NONE = 0;
    localparam int MODE_SEND = 1;
    localparam int MODE_RECV = 2;
    localparam int MODE_BOTH = 3;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    in_t               in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    out_t              out_data;
    logic              cfg_we    = 1'b0;
    logic [FILL_W-1:0] cfg_data  = '0;

    int mismatches;
    int pending;
    int cycles         = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit pressure_on    = 1'b0;
    bit hold_off       = 1'b0;

    // working set for the random references
    logic [PAGE_W-1:0] ws_base = '0;
    int                ws_size = 1;
    int                cap_now = MAX_FRAMES;

    lru_page_replacement i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    page_table_checker i_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // watchdog: anything still running at the limit has hung
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: random stalls, forced low for the whole hold-off
    always @(posedge clk)
        out_ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);

    // one long hold-off, counted here, so the block backs up onto its input
    initial
    begin
        wait (pressure_on);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Offer one reference word. Valid is only lowered while idling, so it is
    // never dropped and raised in the same step between back-to-back words.
    task automatic send_word(logic [PAGE_W-1:0] page, logic last_req);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid             <= 1'b1;
        in_data.page         <= page;
        in_data.last_request <= last_req;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Stop offering and wait until every result word has come back. The
    // first edge lets the checker's count catch up with the last acceptance.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Capacity write, only with the block idle; it empties the frame table.
    task automatic set_frames(logic [FILL_W-1:0] value);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cap_now = (value == 0) ? 1 : (value > MAX_FRAMES) ? MAX_FRAMES : int'(value);
    endtask

    // Mostly references from a small working set around the capacity, so
    // hits, fills and evictions all turn up; the rest anywhere in page space.
    function automatic logic [PAGE_W-1:0] next_page();
        if ($urandom_range(0, 99) < 80)
            return ws_base + PAGE_W'($urandom_range(0, ws_size - 1));
        return PAGE_W'($urandom_range(0, 1023));
    endfunction

    initial
    begin
        logic [FILL_W-1:0] setting;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: eight frames after reset. Fill, hits, then evictions,
        // with page 0 and page 1023 to set every page bit both ways.
        send_word(10'd0, 1'b0);
        send_word(10'd1023, 1'b1);
        send_word(10'd5, 1'b0);
        send_word(10'd0, 1'b0);       // hit
        send_word(10'd1023, 1'b0);    // hit
        send_word(10'd6, 1'b0);
        send_word(10'd7, 1'b0);
        send_word(10'd8, 1'b0);
        send_word(10'd9, 1'b0);
        send_word(10'd10, 1'b0);      // table now full
        send_word(10'd11, 1'b0);      // replaces the oldest
        send_word(10'd5, 1'b0);       // evicted earlier, faults again
        send_word(10'd11, 1'b1);      // hit on a replaced frame
        send_word(10'd0, 1'b0);

        // capacity of zero behaves as one frame
        set_frames(4'd0);
        send_word(10'd3, 1'b0);
        send_word(10'd3, 1'b0);       // hit
        send_word(10'd1023, 1'b1);    // evicts 3
        send_word(10'd3, 1'b0);

        // oversize capacity behaves as the full table
        set_frames(4'd15);
        send_word(10'd2, 1'b0);
        send_word(10'd1023, 1'b0);
        send_word(10'd2, 1'b1);       // hit

        // Random phases: a new capacity each time, extremes included, and
        // the idling mode rotating through all four.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       setting = 4'd8;
                1:       setting = 4'd1;
                2:       setting = 4'd15;
                3:       setting = 4'd0;
                4:       setting = 4'd3;
                5:       setting = 4'd5;
                6:       setting = 4'd2;
                default: setting = 4'd7;
            endcase
            set_frames(setting);
            case (p % 4)
                MODE_NONE:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                MODE_SEND:
                begin
                    send_idle_pct  = 64;
                    recv_stall_pct = 0;
                end
                MODE_RECV:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 64;
                end
                default:
                begin
                    send_idle_pct  = 36;
                    recv_stall_pct = 36;
                end
            endcase
            if (p == 2)
                pressure_on = 1'b1;
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                if (k % WS_REFRESH == 0)
                begin
                    ws_base = PAGE_W'($urandom_range(0, 1023));
                    ws_size = $urandom_range(1, cap_now + 3);
                end
                send_word(next_page(), logic'($urandom_range(0, 7) == 0));
            end
        end

        // Single frame, alternating pages: every word faults, and every word after the first evicts.
        set_frames(4'd1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int k = 0; k < SAT_WORDS; k++)
            send_word(k[0] ? 10'd1023 : 10'd0, logic'(k[0]));

        // a few more with hits and faults on two frames
        set_frames(4'd2);
        ws_base = PAGE_W'($urandom_range(0, 1023));
        ws_size = 3;
        for (int k = 0; k < 20; k++)
            send_word(next_page(), logic'($urandom_range(0, 1)));

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lrupr_pkg.sv
rtl/lrupr_cell.sv
rtl/lru_page_replacement.sv
sim/page_table_checker.sv
sim/tb.sv
